[sv/fkvcp_pkg.sv]
// fkvcp_pkg: constants, types and key table for the framed key/value command parser
// no dependencies; used by framed_key_value_command_parser
package fkvcp_pkg;

  // frame capacity in data bytes, markers excluded
  localparam int MAX_FRAME_BYTES = 128;
  // room kept for the terminator
  localparam int FRAME_SPARE     = 4;
  localparam int FRAME_LEN_W     = $clog2(MAX_FRAME_BYTES + 1);

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 16;
  localparam int NUM_TGT  = 3;
  localparam int NUM_KEYS = 4;
  localparam int KEY_MAX_LEN = 10;
  localparam int KEY_POS_W   = 4;
  localparam logic [KEY_POS_W-1:0] KEY_POS_MAX = '1;

  // byte codes
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;  // newline
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // parse phase within a line
  typedef enum logic [1:0] {
    PH_KEY  = 2'd0,
    PH_LEAD = 2'd1,
    PH_DIG  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // key index doubles as write target; the end key selects no target
  typedef enum logic [1:0] {
    TGT_LEFT  = 2'd0,
    TGT_RIGHT = 2'd1,
    TGT_AUTO  = 2'd2,
    TGT_NONE  = 2'd3
  } target_t;

  localparam int KEY_END = 3;

  localparam logic [BYTE_W-1:0] KEY_TEXT [NUM_KEYS][KEY_MAX_LEN] = '{
    '{"l", "M", "o", "t", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "M", "o", "t", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "u", "t", "o", "n", "o", "m", "o", "u", "s"},
    '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [KEY_POS_W-1:0] KEY_LEN [NUM_KEYS] = '{4'd6, 4'd6, 4'd10, 4'd3};

  // character of key k at position pos, zero beyond the table
  function automatic logic [BYTE_W-1:0] key_char(input int k, input logic [KEY_POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    c = '0;
    if (pos < KEY_POS_W'(KEY_MAX_LEN)) begin
      c = KEY_TEXT[k][pos];
    end
    return c;
  endfunction

endpackage

[sv/framed_key_value_command_parser.sv]
// framed_key_value_command_parser: byte-stream parser for <key=value\n ...> command frames
// depends on fkvcp_pkg (constants, key table, phase and target types)
//
// Takes one ASCII byte per transaction and returns one result transaction per byte.
// Bytes are ignored until '<' opens a frame; inside, key=value lines set the left
// motor, right motor and autonomous values, the key "end" stops parsing, and '>'
// commits the values written in the frame at once (out_tlast high) or, when the
// frame held more than MAX_FRAME_BYTES-4 data bytes, commits nothing and flags
// overflow. Values decode like atoi into 16 bits that wrap. A byte is accepted in
// every cycle while results are taken; its result goes from the input register
// to the result register through the one-byte parse step between them. While
// a result waits for out_tready one more byte is taken into the input register,
// after which in_tready stays low until the waiting result leaves.
module framed_key_value_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] left_motor, [31:16] right_motor,
                                  // [32] autonomous_on, [39:33] zero
  output logic        out_tlast,  // frame_done
  output logic [1:0]  out_tuser   // [0] frame_overflow, [1] receiving
);

  localparam int BW = fkvcp_pkg::BYTE_W;
  localparam int VW = fkvcp_pkg::VALUE_W;
  localparam int LW = fkvcp_pkg::FRAME_LEN_W;
  localparam int PW = fkvcp_pkg::KEY_POS_W;
  localparam int NT = fkvcp_pkg::NUM_TGT;
  localparam int NK = fkvcp_pkg::NUM_KEYS;

  // handshake and pipeline registers
  logic          s1_vld_r;
  logic [BW-1:0] s1_byte_r;
  logic          out_vld_r;
  logic [VW-1:0] out_left_r, out_right_r;
  logic          out_auto_r, out_done_r, out_ovf_r, out_recv_r;
  logic          out_free;
  logic          s1_fire;

  // parser state
  logic                 in_frame_r, in_frame_nxt;
  fkvcp_pkg::phase_t    phase_r, phase_nxt;
  logic [NK-1:0]        mask_r, mask_nxt;
  logic [PW-1:0]        kpos_r, kpos_nxt;
  fkvcp_pkg::target_t   tgt_r, tgt_nxt;
  logic [VW-1:0]        acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic [VW-1:0]        pend_r [NT];
  logic [VW-1:0]        pend_nxt [NT];
  logic [NT-1:0]        pwr_r, pwr_nxt;
  logic                 end_r, end_nxt;
  logic [LW-1:0]        flen_r, flen_nxt;
  logic [VW-1:0]        com_r [NT];
  logic [VW-1:0]        com_nxt [NT];
  logic                 done_nxt, ovf_nxt;

  // pipeline flow
  assign out_free  = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;

  // one parse step for the byte in the input register
  always_comb begin
    logic [BW-1:0] b;
    logic          is_digit, is_blank;
    logic [VW-1:0] acc_dig, fin_val;
    int            hit;
    b        = s1_byte_r;
    is_digit = (b >= fkvcp_pkg::CH_ZERO) && (b <= fkvcp_pkg::CH_NINE);
    is_blank = (b == fkvcp_pkg::CH_SP) || (b == fkvcp_pkg::CH_TAB) ||
               (b == fkvcp_pkg::CH_VT) || (b == fkvcp_pkg::CH_FF) ||
               (b == fkvcp_pkg::CH_CR);
    // accum * 10 + digit, wrapping at 16 bits
    acc_dig  = {acc_r[VW-4:0], 3'b000} + {acc_r[VW-2:0], 1'b0} + {{(VW-4){1'b0}}, b[3:0]};
    fin_val  = neg_r ? (VW'(0) - acc_r) : acc_r;
    hit      = -1;

    in_frame_nxt = in_frame_r;
    phase_nxt    = phase_r;
    mask_nxt     = mask_r;
    kpos_nxt     = kpos_r;
    tgt_nxt      = tgt_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    pwr_nxt      = pwr_r;
    end_nxt      = end_r;
    flen_nxt     = flen_r;
    done_nxt     = 1'b0;
    ovf_nxt      = 1'b0;
    for (int i = 0; i < NT; i++) begin
      pend_nxt[i] = pend_r[i];
      com_nxt[i]  = com_r[i];
    end

    if (!in_frame_r) begin
      // idle between frames: wait for the opening marker
      if (b == fkvcp_pkg::CH_OPEN) begin
        in_frame_nxt = 1'b1;
      end
    end else if (b == fkvcp_pkg::CH_CLOSE) begin
      // closing marker: commit or flag overflow
      if (flen_r > LW'(fkvcp_pkg::MAX_FRAME_BYTES - fkvcp_pkg::FRAME_SPARE)) begin
        ovf_nxt = 1'b1;
      end else begin
        if (!end_r && (phase_r != fkvcp_pkg::PH_KEY) && (tgt_r != fkvcp_pkg::TGT_NONE)) begin
          pend_nxt[tgt_r] = fin_val;
          pwr_nxt[tgt_r]  = 1'b1;
        end
        for (int i = 0; i < NT; i++) begin
          if (pwr_nxt[i]) begin
            com_nxt[i] = pend_nxt[i];
          end
        end
        done_nxt = 1'b1;
      end
      in_frame_nxt = 1'b0;
    end else begin
      // data byte inside a frame
      if (flen_r < LW'(fkvcp_pkg::MAX_FRAME_BYTES)) begin
        flen_nxt = flen_r + LW'(1);
      end
      if (!end_r) begin
        if (phase_r == fkvcp_pkg::PH_KEY) begin
          if (b == fkvcp_pkg::CH_EQ) begin
            // first live candidate whose length matches
            for (int i = NK - 1; i >= 0; i--) begin
              if (mask_r[i] && (kpos_r == fkvcp_pkg::KEY_LEN[i])) begin
                hit = i;
              end
            end
            if (hit == fkvcp_pkg::KEY_END) begin
              end_nxt = 1'b1;
            end else begin
              tgt_nxt   = (hit >= 0) ? fkvcp_pkg::target_t'(hit[1:0]) : fkvcp_pkg::TGT_NONE;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              phase_nxt = fkvcp_pkg::PH_LEAD;
            end
          end else begin
            // drop candidates that disagree at this position
            for (int i = 0; i < NK; i++) begin
              if ((kpos_r >= fkvcp_pkg::KEY_LEN[i]) || (fkvcp_pkg::key_char(i, kpos_r) != b)) begin
                mask_nxt[i] = 1'b0;
              end
            end
            if (kpos_r != fkvcp_pkg::KEY_POS_MAX) begin
              kpos_nxt = kpos_r + PW'(1);
            end
          end
        end else if (b == fkvcp_pkg::CH_NL) begin
          // end of line: store the value, start the next key
          if (tgt_r != fkvcp_pkg::TGT_NONE) begin
            pend_nxt[tgt_r] = fin_val;
            pwr_nxt[tgt_r]  = 1'b1;
          end
          tgt_nxt   = fkvcp_pkg::TGT_NONE;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          phase_nxt = fkvcp_pkg::PH_KEY;
          mask_nxt  = '1;
          kpos_nxt  = '0;
        end else begin
          unique case (phase_r)
            fkvcp_pkg::PH_LEAD: begin
              if (is_blank) begin
                phase_nxt = fkvcp_pkg::PH_LEAD;
              end else if ((b == fkvcp_pkg::CH_PLUS) || (b == fkvcp_pkg::CH_MINUS)) begin
                neg_nxt   = (b == fkvcp_pkg::CH_MINUS);
                phase_nxt = fkvcp_pkg::PH_DIG;
              end else if (is_digit) begin
                acc_nxt   = acc_dig;
                phase_nxt = fkvcp_pkg::PH_DIG;
              end else begin
                phase_nxt = fkvcp_pkg::PH_SKIP;
              end
            end
            fkvcp_pkg::PH_DIG: begin
              if (is_digit) begin
                acc_nxt = acc_dig;
              end else begin
                phase_nxt = fkvcp_pkg::PH_SKIP;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end

    // frame open or close starts a clean parse
    if ((!in_frame_r && (b == fkvcp_pkg::CH_OPEN)) ||
        (in_frame_r && (b == fkvcp_pkg::CH_CLOSE))) begin
      phase_nxt = fkvcp_pkg::PH_KEY;
      mask_nxt  = '1;
      kpos_nxt  = '0;
      tgt_nxt   = fkvcp_pkg::TGT_NONE;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      pwr_nxt   = '0;
      end_nxt   = 1'b0;
      flen_nxt  = '0;
      for (int i = 0; i < NT; i++) begin
        pend_nxt[i] = '0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      phase_r    <= fkvcp_pkg::PH_KEY;
      mask_r     <= '1;
      kpos_r     <= '0;
      tgt_r      <= fkvcp_pkg::TGT_NONE;
      acc_r      <= '0;
      neg_r      <= 1'b0;
      pwr_r      <= '0;
      end_r      <= 1'b0;
      flen_r     <= '0;
      for (int i = 0; i < NT; i++) begin
        pend_r[i] <= '0;
        com_r[i]  <= '0;
      end
    end else if (s1_fire) begin
      in_frame_r <= in_frame_nxt;
      phase_r    <= phase_nxt;
      mask_r     <= mask_nxt;
      kpos_r     <= kpos_nxt;
      tgt_r      <= tgt_nxt;
      acc_r      <= acc_nxt;
      neg_r      <= neg_nxt;
      pwr_r      <= pwr_nxt;
      end_r      <= end_nxt;
      flen_r     <= flen_nxt;
      for (int i = 0; i < NT; i++) begin
        pend_r[i] <= pend_nxt[i];
        com_r[i]  <= com_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
    if (s1_fire) begin
      out_left_r  <= com_nxt[fkvcp_pkg::TGT_LEFT];
      out_right_r <= com_nxt[fkvcp_pkg::TGT_RIGHT];
      out_auto_r  <= (com_nxt[fkvcp_pkg::TGT_AUTO] != '0);
      out_done_r  <= done_nxt;
      out_ovf_r   <= ovf_nxt;
      out_recv_r  <= in_frame_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_auto_r, out_right_r, out_left_r};
  assign out_tlast  = out_done_r;
  assign out_tuser  = {out_recv_r, out_ovf_r};

  // a close transaction never reports both commit and overflow
  a_done_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_done_r && out_ovf_r))
    else $error("commit and overflow flagged together");

  // a closed frame leaves the parser outside any frame
  a_close_not_recv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_done_r || out_ovf_r)) |-> !out_recv_r)
    else $error("receiving after frame close");

  // outside a frame the length count is clear
  a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (flen_r == '0))
    else $error("frame length not cleared outside frame");

  // end key only seen inside a frame
  a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    end_r |-> in_frame_r)
    else $error("end key flag outside frame");

  // length count saturates at capacity
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    flen_r <= LW'(fkvcp_pkg::MAX_FRAME_BYTES))
    else $error("frame length beyond capacity");

endmodule

[tb/sv/framed_key_value_command_parser_tb.sv]
// framed_key_value_command_parser_tb: self-checking stream testbench for the command parser
// depends on fkvcp_pkg and framed_key_value_command_parser; predicts every result transaction
// and checks it field by field, with random sender gaps and receiver stalls
module framed_key_value_command_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 50000;
  localparam int RANDOM_BYTES = 150;
  localparam int NUM_KW       = 4;
  localparam int KW_STOP      = 3;  // index of the "end" keyword
  localparam int KW_LEN [NUM_KW] = '{6, 6, 10, 3};

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // one result transaction as seen on the output
  typedef struct packed {
    logic signed [15:0] left_motor;
    logic signed [15:0] right_motor;
    logic               autonomous_on;
    logic               frame_done;
    logic               frame_overflow;
    logic               receiving;
  } cmd_outputs_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  framed_key_value_command_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser shadow state
  logic                p_in_frame;
  fkvcp_pkg::phase_t   p_phase;
  logic [3:0]          p_live;
  logic [3:0]          p_keypos;
  fkvcp_pkg::target_t  p_target;
  logic [15:0]         p_accum;
  logic                p_neg;
  logic [15:0]         p_pending [3];
  logic [2:0]          p_written;
  logic                p_end;
  int                  p_len;
  logic [15:0]         p_committed [3];

  cmd_outputs_t outputs_due [$];
  logic [7:0]   stim_q [$];

  // sender and receiver controls
  bit       gaps_on = 1'b0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_len_req = 0;
  int       hold_req_id = 0;
  int       hold_seen_id = 0;
  int       hold_left = 0;
  int       rx_phase_cnt = 0;

  // bookkeeping
  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int commits_seen = 0;
  int overflows_seen = 0;
  int stall_cycles = 0;
  int cycle_count = 0;

  // keyword characters, first character at position 0
  function automatic logic [7:0] kw_byte(input int k, input int pos);
    logic [79:0] txt;
    case (k)
      0:       txt = "lMotor";
      1:       txt = "rMotor";
      2:       txt = "autonomous";
      default: txt = "end";
    endcase
    return txt[(KW_LEN[k] - 1 - pos) * 8 +: 8];
  endfunction

  function automatic void begin_key();
    p_phase  = fkvcp_pkg::PH_KEY;
    p_live   = 4'hF;
    p_keypos = '0;
  endfunction

  function automatic void reset_frame_parse();
    begin_key();
    p_target  = fkvcp_pkg::TGT_NONE;
    p_accum   = '0;
    p_neg     = 1'b0;
    p_pending = '{default: '0};
    p_written = '0;
    p_end     = 1'b0;
    p_len     = 0;
  endfunction

  // store the value in progress into its target, if any
  function automatic void finish_value();
    if (p_target != fkvcp_pkg::TGT_NONE) begin
      p_pending[int'(p_target)] = p_neg ? 16'd0 - p_accum : p_accum;
      p_written[int'(p_target)] = 1'b1;
    end
    p_target = fkvcp_pkg::TGT_NONE;
    p_accum  = '0;
    p_neg    = 1'b0;
  endfunction

  // one data byte inside a frame, before any end key
  function automatic void parse_data_byte(input logic [7:0] b);
    logic is_digit;
    int   hit;
    int   i;
    is_digit = (b >= fkvcp_pkg::CH_ZERO) && (b <= fkvcp_pkg::CH_NINE);
    if (p_phase == fkvcp_pkg::PH_KEY) begin
      if (b == fkvcp_pkg::CH_EQ) begin
        hit = -1;
        for (i = 0; i < NUM_KW; i++) begin
          if (hit < 0 && p_live[i] && int'(p_keypos) == KW_LEN[i]) hit = i;
        end
        if (hit == KW_STOP) begin
          p_end = 1'b1;
        end else begin
          p_target = (hit >= 0) ? fkvcp_pkg::target_t'(hit) : fkvcp_pkg::TGT_NONE;
          p_accum  = '0;
          p_neg    = 1'b0;
          p_phase  = fkvcp_pkg::PH_LEAD;
        end
      end else begin
        for (i = 0; i < NUM_KW; i++) begin
          if (int'(p_keypos) >= KW_LEN[i] || kw_byte(i, int'(p_keypos)) != b) p_live[i] = 1'b0;
        end
        if (p_keypos != 4'hF) p_keypos = p_keypos + 4'd1;
      end
    end else if (b == fkvcp_pkg::CH_NL) begin
      finish_value();
      begin_key();
    end else if (p_phase == fkvcp_pkg::PH_LEAD) begin
      if (b == fkvcp_pkg::CH_SP || b == fkvcp_pkg::CH_TAB || b == fkvcp_pkg::CH_VT ||
          b == fkvcp_pkg::CH_FF || b == fkvcp_pkg::CH_CR) begin
        // leading blank, skipped
      end else if (b == fkvcp_pkg::CH_PLUS || b == fkvcp_pkg::CH_MINUS) begin
        p_neg   = (b == fkvcp_pkg::CH_MINUS);
        p_phase = fkvcp_pkg::PH_DIG;
      end else if (is_digit) begin
        p_accum = p_accum * 16'd10 + 16'(b - fkvcp_pkg::CH_ZERO);
        p_phase = fkvcp_pkg::PH_DIG;
      end else begin
        p_phase = fkvcp_pkg::PH_SKIP;
      end
    end else if (p_phase == fkvcp_pkg::PH_DIG) begin
      if (is_digit) p_accum = p_accum * 16'd10 + 16'(b - fkvcp_pkg::CH_ZERO);
      else p_phase = fkvcp_pkg::PH_SKIP;
    end
  endfunction

  // advance the shadow parser by one accepted byte and queue the result it causes
  function automatic void advance_parser(input logic [7:0] b);
    cmd_outputs_t r;
    int i;
    r = '0;
    if (!p_in_frame) begin
      if (b == fkvcp_pkg::CH_OPEN) begin
        reset_frame_parse();
        p_in_frame = 1'b1;
      end
    end else if (b == fkvcp_pkg::CH_CLOSE) begin
      if (p_len > fkvcp_pkg::MAX_FRAME_BYTES - fkvcp_pkg::FRAME_SPARE) begin
        r.frame_overflow = 1'b1;
      end else begin
        if (!p_end && p_phase != fkvcp_pkg::PH_KEY) finish_value();
        for (i = 0; i < 3; i++) begin
          if (p_written[i]) p_committed[i] = p_pending[i];
        end
        r.frame_done = 1'b1;
      end
      p_in_frame = 1'b0;
      reset_frame_parse();
    end else begin
      if (p_len < fkvcp_pkg::MAX_FRAME_BYTES) p_len++;
      if (!p_end) parse_data_byte(b);
    end
    r.left_motor    = p_committed[int'(fkvcp_pkg::TGT_LEFT)];
    r.right_motor   = p_committed[int'(fkvcp_pkg::TGT_RIGHT)];
    r.autonomous_on = (p_committed[int'(fkvcp_pkg::TGT_AUTO)] != 16'd0);
    r.receiving     = p_in_frame;
    outputs_due.push_back(r);
  endfunction

  // ---------------- stimulus building ----------------

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) stim_q.push_back(s[i]);
  endfunction

  function automatic void push_kw(input int k, input int n);
    int i;
    for (i = 0; i < n; i++) stim_q.push_back(kw_byte(k, i));
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 4))
      0:       return fkvcp_pkg::CH_TAB;
      1:       return fkvcp_pkg::CH_VT;
      2:       return fkvcp_pkg::CH_FF;
      3:       return fkvcp_pkg::CH_CR;
      default: return fkvcp_pkg::CH_SP;
    endcase
  endfunction

  // frame whose only line carries a long run of blanks before the value
  function automatic void push_padded_frame(input int blanks, input string value);
    push_text("<lMotor=");
    repeat (blanks) stim_q.push_back(fkvcp_pkg::CH_SP);
    push_text(value);
    push_text("\n>");
  endfunction

  // one key=value line, mostly well formed
  function automatic void push_random_line();
    int sel;
    int n;
    int k;
    sel = $urandom_range(0, 19);
    if (sel < 5) begin
      push_kw(0, KW_LEN[0]);
    end else if (sel < 10) begin
      push_kw(1, KW_LEN[1]);
    end else if (sel < 14) begin
      push_kw(2, KW_LEN[2]);
    end else if (sel == 14) begin
      push_kw(KW_STOP, KW_LEN[KW_STOP]);
    end else if (sel == 15) begin
      n = $urandom_range(1, 8);
      repeat (n) stim_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
    end else if (sel == 16) begin
      k = $urandom_range(0, NUM_KW - 1);
      push_kw(k, $urandom_range(1, KW_LEN[k] - 1));
    end else if (sel == 17) begin
      k = $urandom_range(0, NUM_KW - 1);
      push_kw(k, KW_LEN[k]);
      stim_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
    end else if (sel == 18) begin
      n = $urandom_range(1, 17);
      repeat (n) stim_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 19) != 0) stim_q.push_back(fkvcp_pkg::CH_EQ);
    if ($urandom_range(0, 1) != 0) repeat ($urandom_range(1, 3)) stim_q.push_back(random_blank());
    case ($urandom_range(0, 5))
      0:       stim_q.push_back(fkvcp_pkg::CH_PLUS);
      1:       stim_q.push_back(fkvcp_pkg::CH_MINUS);
      default: ;
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
    repeat (n) stim_q.push_back(fkvcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) begin
      stim_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end
    stim_q.push_back(fkvcp_pkg::CH_NL);
  endfunction

  // noise, then a frame that is sometimes cut short, overlong or left open
  function automatic void build_random_frame();
    int first;
    int pad;
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) begin
      stim_q.push_back(8'($urandom_range(0, 255)));
    end
    first = stim_q.size();
    stim_q.push_back(fkvcp_pkg::CH_OPEN);
    repeat ($urandom_range(1, 4)) push_random_line();
    if ($urandom_range(0, 11) == 0) begin
      pad = $urandom_range(95, 125);
      push_text("autonomous=");
      repeat (pad) stim_q.push_back(fkvcp_pkg::CH_SP);
      push_text("3\n");
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) begin
      if (stim_q.size() > first + 1) void'(stim_q.pop_back());
    end
    if ($urandom_range(0, 29) != 0) stim_q.push_back(fkvcp_pkg::CH_CLOSE);
  endfunction

  // ---------------- sender ----------------

  // one input transaction; valid drops after it when a gap follows or the run ends
  task automatic send_byte(input logic [7:0] b, input bit is_last);
    int gap;
    gap = 0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_parser(b);
    bytes_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
    if (is_last || gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_stim();
    int i;
    for (i = 0; i < stim_q.size(); i++) send_byte(stim_q[i], i == stim_q.size() - 1);
    stim_q.delete();
  endtask

  task automatic wait_results_drained();
    while (outputs_due.size() != 0) @(posedge clk);
  endtask

  // ---------------- receiver ----------------

  // ready pattern at the falling edge; a requested hold-off is counted down here
  always @(negedge clk) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id = hold_req_id;
      hold_left    = hold_len_req;
    end
    rx_phase_cnt++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_tready <= ((rx_phase_cnt % 7) < 4);
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  // ---------------- checking ----------------

  function automatic void check_field(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, what, want_v, got_v);
    end
  endfunction

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    cmd_outputs_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tlast) commits_seen++;
      if (out_tuser[0]) overflows_seen++;
      if (outputs_due.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with nothing expected, expected none actual %h",
                 $realtime, out_tdata);
      end else begin
        want = outputs_due.pop_front();
        check_field("left_motor", want.left_motor, $signed(out_tdata[15:0]));
        check_field("right_motor", want.right_motor, $signed(out_tdata[31:16]));
        check_field("autonomous_on", want.autonomous_on, out_tdata[32]);
        check_field("tdata padding", 0, out_tdata[39:33]);
        check_field("frame_done", want.frame_done, out_tlast);
        check_field("frame_overflow", want.frame_overflow, out_tuser[0]);
        check_field("receiving", want.receiving, out_tuser[1]);
      end
    end
  end

  // cycle limit and input stall count
  always @(posedge clk) begin
    cycle_count++;
    if (in_tvalid && !in_tready) stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               outputs_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------

  // bytes outside a frame, including a stray close and both all-zero and all-one bytes
  task automatic test_outside_frame();
    stim_q.push_back(8'h00);
    stim_q.push_back(8'hFF);
    stim_q.push_back(fkvcp_pkg::CH_CLOSE);
    push_text("lMotor=1\n");
    stim_q.push_back(8'hA5);
    stim_q.push_back(8'h5A);
    send_stim();
  endtask

  // each recognized key, then a frame that leaves other targets unwritten
  task automatic test_key_values();
    push_text("<lMotor=123\nrMotor=-45\nautonomous=1\n>");
    push_text("<autonomous=0\n>");
    send_stim();
  endtask

  // extremes, wrapping, blanks, signs, empty and non-numeric values
  task automatic test_value_decoding();
    push_text("<lMotor=  +32767\nrMotor=-32768\nautonomous=70000\n>");
    push_text("<lMotor=");
    stim_q.push_back(fkvcp_pkg::CH_TAB);
    stim_q.push_back(fkvcp_pkg::CH_VT);
    stim_q.push_back(fkvcp_pkg::CH_FF);
    stim_q.push_back(fkvcp_pkg::CH_CR);
    push_text("-7\nrMotor=12abc34\nautonomous=x5\n>");
    push_text("<lMotor=\nrMotor=-\n>");
    push_text("<lMotor=99999999999\nrMotor=65535\n>");
    send_stim();
  endtask

  // unknown, near-miss and overlong keys; open marker and zero byte as plain data
  task automatic test_key_corners();
    push_text("<lMotor=5\nfoo=7\nlMotorX=3\nlMot=4\nautonomousautonomous=9\n");
    push_text("lMo\ntor=6\n=8\n<rMotor=2\n");
    stim_q.push_back(8'h00);
    push_text("rMotor=3\nrMotor=1<2\n>");
    send_stim();
  endtask

  // frame closed inside a key, inside a value and before any value byte
  task automatic test_close_mid_line();
    push_text("<lMotor=5\nrMot>");
    push_text("<rMotor=77>");
    push_text("<lMotor=>");
    push_text("<rMotor=1\nautonomous=4 x>");
    send_stim();
  endtask

  // end key stops parsing; a bare end with no equals sign is just a key
  task automatic test_end_key();
    push_text("<lMotor=11\nend=\nrMotor=99\n>");
    push_text("<rMotor=8\nend=rMotor=3\nlMotor=1\n>");
    push_text("<end>");
    send_stim();
  endtask

  // frame length right at the limit, one past it, far past it, and past it after end
  task automatic test_capacity();
    push_padded_frame(fkvcp_pkg::MAX_FRAME_BYTES - fkvcp_pkg::FRAME_SPARE - 9, "7");
    push_padded_frame(fkvcp_pkg::MAX_FRAME_BYTES - fkvcp_pkg::FRAME_SPARE - 8, "8");
    push_padded_frame(fkvcp_pkg::MAX_FRAME_BYTES + 8, "9");
    push_text("<end=");
    repeat (fkvcp_pkg::MAX_FRAME_BYTES - fkvcp_pkg::FRAME_SPARE) stim_q.push_back(8'h41);
    push_text(">");
    send_stim();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_len_req = 80;
    hold_req_id++;
    repeat (2) push_text("<lMotor=-1234\nrMotor=+42\nautonomous=7\n>");
    send_stim();
    wait_results_drained();
  endtask

  // random frames under changing sender gaps and receiver stall patterns
  task automatic test_random_frames();
    int first_byte;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      build_random_frame();
      send_stim();
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
  endtask

  initial begin
    p_in_frame  = 1'b0;
    p_committed = '{default: '0};
    reset_frame_parse();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    test_outside_frame();
    test_key_values();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    test_value_decoding();
    test_key_corners();
    rx_mode = RX_PATTERN;
    test_close_mid_line();
    test_end_key();
    wait_results_drained();
    test_capacity();
    wait_results_drained();
    test_backpressure();
    test_random_frames();

    wait_results_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d input bytes and %0d checked results over %0d cycles", bytes_sent,
             results_seen, cycle_count);
    $display("frames committed %0d, frames overflowed %0d, input stall cycles %0d",
             commits_seen, overflows_seen, stall_cycles);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[framed_key_value_command_parser.f]
sv/fkvcp_pkg.sv
sv/framed_key_value_command_parser.sv
tb/sv/framed_key_value_command_parser_tb.sv
